// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL of the decimal converter, used by adf_core.
// Both macros expect clk_i and rst_ni to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ADF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define ADF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/adf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package adf_pkg;

  // Character limit per number, the sign included.
  localparam int MaxChars = 16;
  localparam int IdxW     = $clog2(MaxChars);
  localparam int CntW     = IdxW + 1;
  localparam logic [CntW-1:0] MaxCharsCnt = CntW'(MaxChars);

  localparam int AccW = 48;
  localparam logic [AccW-1:0] AccLimit   = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0]     ScaleTenth = 32'h1999_999A;
  localparam logic [31:0]     PosLimit   = 32'h7FFF_FFFF;
  localparam logic [31:0]     NegLimit   = 32'h8000_0000;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] DigitMask = 8'h0F;

  typedef enum logic [1:0] {
    EndTerminator = 2'd0,
    EndInvalid    = 2'd1,
    EndLength     = 2'd2
  } end_cause_e;

  // Character held in the input register, handed to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
  } adf_char_t;

endpackage

`default_nettype wire

// ----- sv/adf_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module adf_in_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       char_code_i,
  output adf_pkg::adf_char_t    char_o,
  input  wire logic             take_i
);

  logic       valid_q, valid_d;
  logic [7:0] code_q;
  logic       load;

  // The register refills in the same cycle that the parser takes its content.
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= char_code_i;
    end
  end

  assign char_o.valid = valid_q;
  assign char_o.code  = code_q;

endmodule

`default_nettype wire

// ----- sv/adf_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module adf_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire adf_pkg::adf_char_t    char_i,
  output logic                       take_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [31:0]         fixed_value_o,
  output logic                       saturated_o,
  output logic [1:0]                 end_cause_o
);

  logic [adf_pkg::AccW-1:0] acc_q, acc_d, acc_upd;
  logic [31:0]              scale_q, scale_d;
  logic                     frac_q, frac_d;
  logic                     neg_q, neg_d, neg_upd;
  logic [adf_pkg::IdxW-1:0] idx_q, idx_d;
  logic                     skip_q, skip_d;
  logic                     ovf_q, ovf_d, ovf_upd;

  logic                     out_valid_q, out_valid_d;
  logic [31:0]              word_q;
  logic                     sat_q;
  adf_pkg::end_cause_e      cause_q;

  logic                     take;
  logic [7:0]               code;
  logic [3:0]               digit;
  logic                     is_digit;
  logic                     counted;
  logic                     emit;
  adf_pkg::end_cause_e      cause;
  logic [adf_pkg::CntW-1:0] idx_wide, idx_inc;

  logic [51:0]              acc_x10;
  logic [52:0]              int_sum;
  logic [35:0]              digit_x_scale;
  logic [48:0]              frac_sum;
  logic [63:0]              scale_prod;

  logic [31:0]              mag, limit, mag_clamped, word;
  logic                     sat;

  assign take = char_i.valid && (!out_valid_q || out_ready_i);
  assign code = char_i.code;
  assign digit = 4'(code & adf_pkg::DigitMask);

  assign idx_wide = adf_pkg::CntW'(idx_q);
  assign idx_inc  = idx_wide + adf_pkg::CntW'(1);

  // Integer digit: acc * 10 + digit in the units position of Q16.32.
  assign acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1);
  assign int_sum = {1'b0, acc_x10} + {17'b0, digit, 32'b0};

  // Fraction digit: acc + digit * scale, then scale becomes scale * 0.1.
  assign digit_x_scale = 36'(digit) * 36'(scale_q);
  assign frac_sum      = {1'b0, acc_q} + {13'b0, digit_x_scale};
  assign scale_prod    = 64'(scale_q) * 64'(adf_pkg::ScaleTenth);

  always_comb begin
    acc_upd  = acc_q;
    ovf_upd  = ovf_q;
    neg_upd  = neg_q;
    scale_d  = scale_q;
    frac_d   = frac_q;
    idx_d    = idx_q;
    skip_d   = skip_q;
    emit     = 1'b0;
    cause    = adf_pkg::EndTerminator;
    counted  = 1'b0;
    is_digit = code inside {[adf_pkg::CharZero:adf_pkg::CharNine]};

    if (skip_q) begin
      if (code == adf_pkg::CharNul) begin
        skip_d = 1'b0;
      end
    end else if (code == adf_pkg::CharNul) begin
      emit  = 1'b1;
      cause = adf_pkg::EndTerminator;
    end else begin
      counted = 1'b1;
      if (code == adf_pkg::CharMinus && idx_q == '0) begin
        neg_upd = 1'b1;
      end else if (code == adf_pkg::CharPoint) begin
        scale_d = adf_pkg::ScaleTenth;
        frac_d  = 1'b1;
      end else if (is_digit) begin
        if (!frac_q) begin
          if (int_sum > {5'b0, adf_pkg::AccLimit}) begin
            acc_upd = adf_pkg::AccLimit;
            ovf_upd = 1'b1;
          end else begin
            acc_upd = int_sum[adf_pkg::AccW-1:0];
          end
        end else begin
          if (frac_sum > {1'b0, adf_pkg::AccLimit}) begin
            acc_upd = adf_pkg::AccLimit;
            ovf_upd = 1'b1;
          end else begin
            acc_upd = frac_sum[adf_pkg::AccW-1:0];
          end
          scale_d = scale_prod[63:32];
        end
      end else begin
        // Any other character, including a minus after the first position.
        counted = 1'b0;
        emit    = 1'b1;
        cause   = adf_pkg::EndInvalid;
      end

      if (counted) begin
        if (idx_inc == adf_pkg::MaxCharsCnt) begin
          emit  = 1'b1;
          cause = adf_pkg::EndLength;
        end else begin
          idx_d = idx_inc[adf_pkg::IdxW-1:0];
        end
      end
    end

    acc_d = acc_upd;
    ovf_d = ovf_upd;
    neg_d = neg_upd;
    if (emit) begin
      acc_d   = '0;
      ovf_d   = 1'b0;
      neg_d   = 1'b0;
      scale_d = adf_pkg::ScaleTenth;
      frac_d  = 1'b0;
      idx_d   = '0;
      skip_d  = (cause != adf_pkg::EndTerminator);
    end
  end

  // Q16.32 magnitude to Q16.16, clamped to the signed range, sign applied.
  assign mag         = acc_upd[adf_pkg::AccW-1:16];
  assign limit       = neg_upd ? adf_pkg::NegLimit : adf_pkg::PosLimit;
  assign sat         = ovf_upd || (mag > limit);
  assign mag_clamped = (mag > limit) ? limit : mag;
  assign word        = neg_upd ? (32'd0 - mag_clamped) : mag_clamped;

  assign out_valid_d = (out_valid_q && !out_ready_i) || (take && emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      scale_q     <= adf_pkg::ScaleTenth;
      frac_q      <= 1'b0;
      neg_q       <= 1'b0;
      idx_q       <= '0;
      skip_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        acc_q   <= acc_d;
        scale_q <= scale_d;
        frac_q  <= frac_d;
        neg_q   <= neg_d;
        idx_q   <= idx_d;
        skip_q  <= skip_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      word_q  <= word;
      sat_q   <= sat;
      cause_q <= cause;
    end
  end

  assign take_o        = take;
  assign out_valid_o   = out_valid_q;
  assign fixed_value_o = signed'(word_q);
  assign saturated_o   = sat_q;
  assign end_cause_o   = cause_q;

  `ADF_ASSERT(a_idx_range, idx_wide < adf_pkg::MaxCharsCnt, "character index past the limit")
  `ADF_ASSERT(a_ovf_holds_limit, !ovf_q || (acc_q == adf_pkg::AccLimit), "overflow without clamp")
  `ADF_ASSERT_NEXT(a_skip_ends, take && skip_q && (code == adf_pkg::CharNul), !skip_q, "skip not left on terminator")
  `ADF_ASSERT_NEXT(a_skip_silent, take && skip_q, !out_valid_q, "result while skipping")
  `ADF_ASSERT_NEXT(a_term_clears, take && !skip_q && (code == adf_pkg::CharNul), out_valid_q && !skip_q && (acc_q == '0), "terminator did not close the number")

endmodule

`default_nettype wire

// ----- sv/ascii_decimal_to_fixed_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ASCII decimal string to signed Q16.16 converter.
// Input channel: one character per request on char_code_i, valid/ready.
// A leading '-' negates, digits and '.' build the number, and it ends on a
// NUL, on any other character, or when the character limit is reached.
// Output channel: one request per number with fixed_value_o, saturated_o
// (clamped magnitude) and end_cause_o (terminator, invalid, length limit).
// After a number that did not end on NUL, characters up to and including
// the next NUL are dropped without a result.
// Throughput: one character per clock cycle while the result register is
// not stalled, set by the state update in the parser. The ending character
// passes through the input register and then the parser into the result
// register, which presents the result on the output channel.
// When the receiver stalls, the result register holds its request and the
// parser takes no character; the input register holds at most one more
// character, and further input waits until the result is accepted.
// Reset clears the number state, the skip mode and both valid flags; the
// block is ready for a new string as soon as reset is released.

module ascii_decimal_to_fixed_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    char_code_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic signed [31:0] fixed_value_o,
  output logic               saturated_o,
  output logic [1:0]         end_cause_o
);

  adf_pkg::adf_char_t char_s;
  logic               take_s;

  adf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_code_i(char_code_i),
    .char_o     (char_s),
    .take_i     (take_s)
  );

  adf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_i       (char_s),
    .take_o       (take_s),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .fixed_value_o(fixed_value_o),
    .saturated_o  (saturated_o),
    .end_cause_o  (end_cause_o)
  );

endmodule

`default_nettype wire
